// ===== src/ilid_pkg.sv =====
// Package for the indexed list insert/delete block.
// Holds the opcode and status codes, the sequencer states and default sizes.
// No dependencies.
`default_nettype none

package ilid_pkg;

  localparam int unsigned CAPACITY_DEF      = 64;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  // Fixed field widths of the stream payloads.
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned POSITION_W = 7;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_REAR  = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_REAR  = 3'd4,
    OP_DEL_AT    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/indexed_list_insert_delete.sv =====
// Indexed list insert/delete: top level with its sequencer and output register.
// Depends on ilid_pkg and ilid_ram.
//
// Usage
// The block keeps an ordered list of up to CAPACITY elements in a RAM plus a
// fill count. Each transaction on the slave stream (s_tvalid/s_tready/s_tdata)
// carries an opcode, a one-based position and a value. Each one produces
// exactly one transaction on the master stream (m_tvalid/m_tready/m_tdata)
// with the removed element, a status code, the new count and an empty flag.
//
// Sequence
// Inserting or deleting shifts the elements behind the position one place
// through the single RAM port pair: a read is issued each cycle and the data
// read in the previous cycle is written one slot further (insert) or one slot
// nearer (delete). An insert or add then writes the new value at its slot
// (S_PUT) before the result is formed (S_DONE); for a delete the first read
// fetches the removed element. Failing operations and unknown opcodes go
// straight to S_DONE. The sequencer is back in idle in the cycle the result
// appears; s_tready is high only while the sequencer is idle, so a new
// operation is only accepted once the previous one has left the sequencer.
//
// Reset and stalls
// Reset (rst, synchronous, active high) empties the list and drops any
// pending result. The RAM contents are not cleared; only entries inside the
// filled range are ever read. A finished result sits in the output register
// until m_tready takes it; the next operation may be accepted meanwhile, but
// its result waits in the sequencer until the output register is free.
`default_nettype none

module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY      = ilid_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = ilid_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream. tdata from bit 0: opcode[2:0], position[6:0], value[31:0], zero pad.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ilid_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Result stream. tdata from bit 0: removed_value[31:0], status[1:0],
  // element_count[6:0], is_empty, zero pad.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [ilid_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = ((CW > ilid_pkg::POSITION_W) ? CW : ilid_pkg::POSITION_W) + 1;
  localparam int unsigned XW = (ELEMENT_WIDTH > ilid_pkg::VALUE_W) ?
                               ELEMENT_WIDTH : ilid_pkg::VALUE_W;

  // Input fields.
  ilid_pkg::op_t                      opcode;
  logic [ilid_pkg::POSITION_W-1:0]    position;
  logic [ilid_pkg::VALUE_W-1:0]       value;

  assign opcode   = ilid_pkg::op_t'(s_tdata[2:0]);
  assign position = s_tdata[9:3];
  assign value    = s_tdata[41:10];

  // Sequencer and list state.
  ilid_pkg::state_t        state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic [AW-1:0]           idx, idx_next;
  logic [AW-1:0]           rd_ptr, rd_ptr_next;
  logic [AW-1:0]           rd_last, rd_last_next;
  logic [CW-1:0]           left, left_next;
  logic                    pend, pend_next;
  logic                    first, first_next;
  logic                    is_ins, is_ins_next;
  logic [ELEMENT_WIDTH-1:0] val_r, val_r_next;
  logic [ELEMENT_WIDTH-1:0] removed, removed_next;
  ilid_pkg::status_t       status, status_next;

  // Output register.
  logic                             m_tvalid_next;
  logic [ilid_pkg::OUT_TDATA_W-1:0] m_tdata_next;

  // RAM port signals.
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [AW-1:0]            raddr;
  logic [ELEMENT_WIDTH-1:0] rdata;

  // Width adaptation between the 32-bit stream fields and the element width.
  logic [XW-1:0]            value_ext;
  logic [XW-1:0]            removed_ext;

  assign value_ext   = XW'(value);
  assign removed_ext = XW'(removed);

  // Decode helpers, evaluated against the current count.
  logic [KW-1:0] pos_ext;
  logic [KW-1:0] cnt_ext;

  assign pos_ext = KW'(position);
  assign cnt_ext = KW'(cnt);

  ilid_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s_tready = (state == ilid_pkg::S_IDLE);

  always_comb begin
    logic          do_ins;
    logic          do_del;
    logic [AW-1:0] op_idx;
    logic [CW-1:0] cnt_after;

    state_next    = state;
    cnt_next      = cnt;
    idx_next      = idx;
    rd_ptr_next   = rd_ptr;
    rd_last_next  = rd_last;
    left_next     = left;
    pend_next     = pend;
    first_next    = first;
    is_ins_next   = is_ins;
    val_r_next    = val_r;
    removed_next  = removed;
    status_next   = status;
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    we            = 1'b0;
    waddr         = rd_last;
    wdata         = rdata;
    raddr         = rd_ptr;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    op_idx        = '0;
    cnt_after     = cnt;

    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end

    case (state)
      ilid_pkg::S_IDLE: begin
        if (s_tvalid) begin
          status_next  = ilid_pkg::ST_OK;
          removed_next = '0;
          val_r_next   = value_ext[ELEMENT_WIDTH-1:0];
          case (opcode)
            ilid_pkg::OP_ADD_FRONT: begin
              if (cnt_ext >= KW'(CAPACITY)) begin
                status_next = ilid_pkg::ST_FULL;
              end else begin
                do_ins = 1'b1;
                op_idx = '0;
              end
            end
            ilid_pkg::OP_ADD_REAR: begin
              if (cnt_ext >= KW'(CAPACITY)) begin
                status_next = ilid_pkg::ST_FULL;
              end else begin
                do_ins = 1'b1;
                op_idx = AW'(cnt);
              end
            end
            ilid_pkg::OP_INSERT_AT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + KW'(1)) begin
                status_next = ilid_pkg::ST_RANGE;
              end else if (cnt_ext >= KW'(CAPACITY)) begin
                status_next = ilid_pkg::ST_FULL;
              end else begin
                do_ins = 1'b1;
                op_idx = AW'(pos_ext - KW'(1));
              end
            end
            ilid_pkg::OP_DEL_FRONT: begin
              if (cnt == '0) begin
                status_next = ilid_pkg::ST_UNDERFLOW;
              end else begin
                do_del = 1'b1;
                op_idx = '0;
              end
            end
            ilid_pkg::OP_DEL_REAR: begin
              if (cnt == '0) begin
                status_next = ilid_pkg::ST_UNDERFLOW;
              end else begin
                do_del = 1'b1;
                op_idx = AW'(cnt_ext - KW'(1));
              end
            end
            ilid_pkg::OP_DEL_AT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_next = ilid_pkg::ST_RANGE;
              end else begin
                do_del = 1'b1;
                op_idx = AW'(pos_ext - KW'(1));
              end
            end
            default: begin
              // Unknown opcodes leave the list alone and report ok.
            end
          endcase

          if (do_ins) begin
            cnt_after = cnt + CW'(1);
          end else if (do_del) begin
            cnt_after = cnt - CW'(1);
          end
          cnt_next = cnt_after;

          // Inserts read from the rear down to the position; deletes read
          // from the position up to the rear, the first read being the
          // element that is removed.
          idx_next    = op_idx;
          is_ins_next = do_ins;
          first_next  = do_del;
          pend_next   = 1'b0;
          left_next   = CW'(cnt_ext - KW'(op_idx));
          rd_ptr_next = do_ins ? AW'(cnt_ext - KW'(1)) : op_idx;

          if (do_ins || do_del) begin
            state_next = ilid_pkg::S_MOVE;
          end else begin
            state_next = ilid_pkg::S_DONE;
          end
        end
      end

      ilid_pkg::S_MOVE: begin
        // Write back the element read in the previous cycle.
        if (pend) begin
          if (first) begin
            removed_next = rdata;
            first_next   = 1'b0;
          end else begin
            we    = 1'b1;
            waddr = is_ins ? (rd_last + AW'(1)) : (rd_last - AW'(1));
            wdata = rdata;
          end
        end
        // Issue the next read, if any are left.
        if (left != '0) begin
          raddr        = rd_ptr;
          rd_last_next = rd_ptr;
          rd_ptr_next  = is_ins ? (rd_ptr - AW'(1)) : (rd_ptr + AW'(1));
          left_next    = left - CW'(1);
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = is_ins ? ilid_pkg::S_PUT : ilid_pkg::S_DONE;
          end
        end
      end

      ilid_pkg::S_PUT: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = val_r;
        state_next = ilid_pkg::S_DONE;
      end

      ilid_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {6'b0,
                           (cnt == '0),
                           ilid_pkg::COUNT_W'(cnt),
                           status,
                           removed_ext[ilid_pkg::VALUE_W-1:0]};
          state_next    = ilid_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ilid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ilid_pkg::S_IDLE;
      cnt      <= '0;
      pend     <= 1'b0;
      first    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      pend     <= pend_next;
      first    <= first_next;
      m_tvalid <= m_tvalid_next;
    end
    idx     <= idx_next;
    rd_ptr  <= rd_ptr_next;
    rd_last <= rd_last_next;
    left    <= left_next;
    is_ins  <= is_ins_next;
    val_r   <= val_r_next;
    removed <= removed_next;
    status  <= status_next;
    m_tdata <= m_tdata_next;
  end

endmodule

`default_nettype wire

// ===== src/ilid_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ilid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
